[hdl/point_in_polygon_test_macros.svh]
// Assertion macros for the point-in-polygon test RTL.
`ifndef POINT_IN_POLYGON_TEST_MACROS_SVH
`define POINT_IN_POLYGON_TEST_MACROS_SVH

`ifndef SYNTHESIS

// The condition must hold at every clock edge outside reset.
`define PPT_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define PPT_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PPT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define PPT_ASSERT_ALWAYS(lbl, cond, msg)
`define PPT_ASSERT_IMPL(lbl, ante, cons, msg)
`define PPT_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

[hdl/ppt_pkg.sv]
// Package with the types and constants of the point-in-polygon test.
`default_nettype none

package ppt_pkg;

    localparam int MAX_VERTICES_DEF = 256;
    localparam int COORD_WIDTH_DEF  = 32;
    localparam int FIELD_W          = 32;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_LOAD  = 2'd1,
        OP_QUERY = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN
    } state_t;

    // Status of the edge pipeline as seen by the sequencer.
    typedef struct packed {
        logic busy;
        logic vld;
        logic hit;
    } edge_res_t;

endpackage

`default_nettype wire

[hdl/ppt_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module ppt_ram #(
    parameter int WIDTH  = 64,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[hdl/ppt_edge_unit.sv]
// Pipelined edge test: straddle check and exact cross-multiplied crossing compare.
`default_nettype none

module ppt_edge_unit
    import ppt_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_vld,
    input  wire logic signed [COORD_WIDTH-1:0] qx,
    input  wire logic signed [COORD_WIDTH-1:0] qy,
    input  wire logic signed [COORD_WIDTH-1:0] xi,
    input  wire logic signed [COORD_WIDTH-1:0] yi,
    input  wire logic signed [COORD_WIDTH-1:0] xj,
    input  wire logic signed [COORD_WIDTH-1:0] yj,
    output edge_res_t                          res
);

    localparam int DW  = COORD_WIDTH + 1;
    localparam int H   = (DW + 1) / 2;
    localparam int HW  = DW - H;
    localparam int PW  = 2 * DW;
    localparam int LLW = 2 * H + 2;
    localparam int LHW = H + 1 + HW;
    localparam int HHW = 2 * HW;

    // Stage 1: differences, with the edge oriented so that dy is positive.
    logic                 straddle;
    logic signed [DW-1:0] d_y;
    logic signed [DW-1:0] ty_raw;
    logic signed [DW-1:0] ty_next;
    logic signed [DW-1:0] dy_next;
    logic signed [DW-1:0] dxa_next;
    logic signed [DW-1:0] dx_next;

    logic                 s1_vld_reg;
    logic signed [DW-1:0] s1_ty_reg;
    logic signed [DW-1:0] s1_dy_reg;
    logic signed [DW-1:0] s1_dxa_reg;
    logic signed [DW-1:0] s1_dx_reg;

    always_comb
    begin
        straddle = ((yi < qy) && (yj >= qy)) || ((yj < qy) && (yi >= qy));
        d_y      = DW'(yj) - DW'(yi);
        ty_raw   = DW'(qy) - DW'(yi);
        ty_next  = d_y[DW-1] ? -ty_raw : ty_raw;
        dy_next  = d_y[DW-1] ? -d_y : d_y;
        dxa_next = DW'(xj) - DW'(xi);
        dx_next  = DW'(qx) - DW'(xi);
    end

    // Stage 2: operands split into an unsigned low half and a signed high half.
    logic signed [H:0]    ty_lo;
    logic signed [H:0]    dxa_lo;
    logic signed [H:0]    dx_lo;
    logic signed [H:0]    dy_lo;
    logic signed [HW-1:0] ty_hi;
    logic signed [HW-1:0] dxa_hi;
    logic signed [HW-1:0] dx_hi;
    logic signed [HW-1:0] dy_hi;

    logic                  s2_vld_reg;
    logic signed [LLW-1:0] l_ll_reg;
    logic signed [LHW-1:0] l_lh_reg;
    logic signed [LHW-1:0] l_hl_reg;
    logic signed [HHW-1:0] l_hh_reg;
    logic signed [LLW-1:0] r_ll_reg;
    logic signed [LHW-1:0] r_lh_reg;
    logic signed [LHW-1:0] r_hl_reg;
    logic signed [HHW-1:0] r_hh_reg;

    always_comb
    begin
        ty_lo  = $signed({1'b0, s1_ty_reg[H-1:0]});
        dxa_lo = $signed({1'b0, s1_dxa_reg[H-1:0]});
        dx_lo  = $signed({1'b0, s1_dx_reg[H-1:0]});
        dy_lo  = $signed({1'b0, s1_dy_reg[H-1:0]});
        ty_hi  = $signed(s1_ty_reg[DW-1:H]);
        dxa_hi = $signed(s1_dxa_reg[DW-1:H]);
        dx_hi  = $signed(s1_dx_reg[DW-1:H]);
        dy_hi  = $signed(s1_dy_reg[DW-1:H]);
    end

    // Stage 3: full products ty*(xj-xi) on the left and (x-xi)*dy on the right.
    logic              s3_vld_reg;
    logic signed [PW-1:0] p_left_reg;
    logic signed [PW-1:0] p_right_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= in_vld && straddle;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_ty_reg  <= ty_next;
        s1_dy_reg  <= dy_next;
        s1_dxa_reg <= dxa_next;
        s1_dx_reg  <= dx_next;

        l_ll_reg <= LLW'(ty_lo) * LLW'(dxa_lo);
        l_lh_reg <= LHW'(ty_lo) * LHW'(dxa_hi);
        l_hl_reg <= LHW'(ty_hi) * LHW'(dxa_lo);
        l_hh_reg <= HHW'(ty_hi) * HHW'(dxa_hi);
        r_ll_reg <= LLW'(dx_lo) * LLW'(dy_lo);
        r_lh_reg <= LHW'(dx_lo) * LHW'(dy_hi);
        r_hl_reg <= LHW'(dx_hi) * LHW'(dy_lo);
        r_hh_reg <= HHW'(dx_hi) * HHW'(dy_hi);

        p_left_reg  <= (PW'(l_hh_reg) <<< (2 * H))
                     + ((PW'(l_lh_reg) + PW'(l_hl_reg)) <<< H)
                     + PW'(l_ll_reg);
        p_right_reg <= (PW'(r_hh_reg) <<< (2 * H))
                     + ((PW'(r_lh_reg) + PW'(r_hl_reg)) <<< H)
                     + PW'(r_ll_reg);
    end

    always_comb
    begin
        res.busy = s1_vld_reg || s2_vld_reg || s3_vld_reg;
        res.vld  = s3_vld_reg;
        res.hit  = p_left_reg < p_right_reg;
    end

endmodule

`default_nettype wire

[hdl/point_in_polygon_test.sv]
// Top level of the even-odd point-in-polygon test with a RAM vertex store.
//
//  channel   | handshake            | payload
//  ----------+----------------------+------------------------------------------
//  item in   | start && !busy       | opcode, coord_x, coord_y
//  result    | done (one cycle)     | inside_res, vertex_total, load_rejected
//
// Clear, load, unused opcodes and a query on an empty store give their result
// beat in the cycle after acceptance, and busy stays low, so items may follow
// back to back. A query on n stored vertices keeps busy high until its result
// beat: the vertex RAM is read once per cycle, n + 1 times in all (the last
// vertex, then every vertex in order), followed by the registered read, the
// edge stages and the flag update. Reset clears the vertex count and all
// control state; the vertex RAM is not cleared, since only entries below the
// count are ever read. The receiver cannot stall.
`default_nettype none

module point_in_polygon_test
    import ppt_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    parameter int COORD_WIDTH  = COORD_WIDTH_DEF
) (
    input  wire logic                                      clk,
    input  wire logic                                      rst_n,
    input  wire logic                                      start,
    output logic                                           busy,
    input  wire logic        [1:0]                         opcode,
    input  wire logic signed [FIELD_W-1:0]                 coord_x,
    input  wire logic signed [FIELD_W-1:0]                 coord_y,
    output logic                                           done,
    output logic                                           inside_res,
    output logic             [$clog2(MAX_VERTICES+1)-1:0]  vertex_total,
    output logic                                           load_rejected
);

`include "point_in_polygon_test_macros.svh"

    localparam int CNT_W = $clog2(MAX_VERTICES + 1);
    localparam int AW    = $clog2(MAX_VERTICES);
    localparam int VW    = 2 * COORD_WIDTH;

    // Handshake and incoming coordinates, cut or sign-extended to the
    // internal coordinate width.
    logic                          accept;
    logic signed [COORD_WIDTH-1:0] cx;
    logic signed [COORD_WIDTH-1:0] cy;

    assign accept = start && !busy;
    assign cx     = COORD_WIDTH'(coord_x);
    assign cy     = COORD_WIDTH'(coord_y);

    // Sequencer and vertex count.
    state_t            state_reg;
    state_t            state_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [CNT_W-1:0]  idx_reg;
    logic              store_full;
    logic              start_walk;
    logic              rd_en;
    logic              walk_end;
    logic              pipe_empty;

    // Read side of the vertex RAM; the read data arrive in the cycle after the read.
    logic              rd_vld_reg;
    logic              rd_first_reg;
    logic [CNT_W-1:0]  last_idx;
    logic [CNT_W-1:0]  idx_prev;
    logic [AW-1:0]     rd_addr;
    logic              ram_we;
    logic [VW-1:0]     rd_data;

    // Query point, running even-odd flag and the previous vertex of the walk.
    logic signed [COORD_WIDTH-1:0] qx_reg;
    logic signed [COORD_WIDTH-1:0] qy_reg;
    logic signed [COORD_WIDTH-1:0] prev_x_reg;
    logic signed [COORD_WIDTH-1:0] prev_y_reg;
    logic signed [COORD_WIDTH-1:0] cur_x;
    logic signed [COORD_WIDTH-1:0] cur_y;
    logic                          inside_reg;
    edge_res_t                     er;

    // Result beat.
    logic              done_reg;
    logic              res_inside_reg;
    logic [CNT_W-1:0]  res_total_reg;
    logic              res_rej_reg;

    assign store_full = count_reg == CNT_W'(MAX_VERTICES);
    assign start_walk = accept && (opcode == OP_QUERY) && (count_reg != '0);
    assign ram_we     = accept && (opcode == OP_LOAD) && !store_full;

    // The count changes only on accepted clears and successful loads.
    always_comb
    begin
        count_next = count_reg;
        if (accept)
        begin
            case (opcode)
                OP_CLEAR: count_next = '0;
                OP_LOAD:
                begin
                    if (!store_full)
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                default:  count_next = count_reg;
            endcase
        end
    end

    // Next-state logic of the query sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start_walk)
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (idx_reg == count_reg)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!rd_vld_reg && !er.busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Output logic of the sequencer. The walk reads the last vertex first, so
    // that the first edge runs from the last vertex to the first one.
    always_comb
    begin
        busy       = state_reg != ST_IDLE;
        rd_en      = state_reg == ST_WALK;
        walk_end   = (state_reg == ST_WALK) && (idx_reg == count_reg);
        pipe_empty = (state_reg == ST_DRAIN) && !rd_vld_reg && !er.busy;
        last_idx   = count_reg - CNT_W'(1);
        idx_prev   = idx_reg - CNT_W'(1);
        rd_addr    = (idx_reg == '0) ? last_idx[AW-1:0] : idx_prev[AW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            idx_reg      <= '0;
            rd_vld_reg   <= 1'b0;
            rd_first_reg <= 1'b0;
            inside_reg   <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            rd_vld_reg   <= rd_en;
            rd_first_reg <= idx_reg == '0;
            done_reg     <= (accept && !start_walk) || pipe_empty;
            if (start_walk)
            begin
                idx_reg    <= '0;
                inside_reg <= 1'b0;
            end
            else
            begin
                if (rd_en && !walk_end)
                begin
                    idx_reg <= idx_reg + CNT_W'(1);
                end
                if (er.vld && er.hit)
                begin
                    inside_reg <= !inside_reg;
                end
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (start_walk)
        begin
            qx_reg <= cx;
            qy_reg <= cy;
        end
        if (rd_vld_reg)
        begin
            prev_x_reg <= cur_x;
            prev_y_reg <= cur_y;
        end
        if (accept && !start_walk)
        begin
            res_inside_reg <= 1'b0;
            res_total_reg  <= count_next;
            res_rej_reg    <= (opcode == OP_LOAD) && store_full;
        end
        else if (pipe_empty)
        begin
            res_inside_reg <= inside_reg;
            res_total_reg  <= count_reg;
            res_rej_reg    <= 1'b0;
        end
    end

    // Vertex store: x in the upper half of a word, y in the lower half.
    ppt_ram #(
        .WIDTH  (VW),
        .DEPTH  (MAX_VERTICES),
        .ADDR_W (AW)
    ) u_vertex_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[AW-1:0]),
        .wdata ({cx, cy}),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    assign cur_x = $signed(rd_data[VW-1:COORD_WIDTH]);
    assign cur_y = $signed(rd_data[COORD_WIDTH-1:0]);

    // The first vertex read of a walk only primes the previous-vertex register;
    // every later read closes one edge with the vertex before it.
    ppt_edge_unit #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_edge (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_vld (rd_vld_reg && !rd_first_reg),
        .qx     (qx_reg),
        .qy     (qy_reg),
        .xi     (cur_x),
        .yi     (cur_y),
        .xj     (prev_x_reg),
        .yj     (prev_y_reg),
        .res    (er)
    );

    assign done          = done_reg;
    assign inside_res    = res_inside_reg;
    assign vertex_total  = res_total_reg;
    assign load_rejected = res_rej_reg;

    // The walk never issues a read past the stored vertices.
    `PPT_ASSERT_IMPL(a_walk_bound, state_reg == ST_WALK, idx_reg <= count_reg, "walk overran count")
    // No read or edge is in flight once the sequencer is back in idle.
    `PPT_ASSERT_IMPL(a_idle_empty, state_reg == ST_IDLE, !rd_vld_reg && !er.busy, "pipe not empty")
    // A walk only starts on a store that holds vertices.
    `PPT_ASSERT_IMPL(a_walk_nonempty, $rose(busy), count_reg != '0, "walk on empty store")
    // A rejected load reports a full store.
    `PPT_ASSERT_IMPL(a_reject_full, done_reg && res_rej_reg, res_total_reg == CNT_W'(MAX_VERTICES), "reject not full")

endmodule

`default_nettype wire
